/* rtl/ggc_pkg.sv */
package ggc_pkg;

    // Store geometry and the cap on vertices in use
    localparam int STORE_DEPTH  = 32;
    localparam int MAX_VERTICES = 32;
    localparam int VTX_W        = 5;
    localparam int CNT_W        = 6;
    localparam int ADJ_W        = 32;

    localparam logic [CNT_W-1:0] CNT_RESET = 6'd32;
    localparam logic [CNT_W-1:0] CNT_CAP   = CNT_W'(MAX_VERTICES < STORE_DEPTH ?
                                                     MAX_VERTICES : STORE_DEPTH);

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PICK,
        ST_DONE
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic scan;
        logic pick;
        logic load;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic in_range;
        logic scan_last;
        logic out_free;
    } t_sts;

endpackage

/* rtl/greedy_graph_coloring_core.sv */
// Greedy graph coloring core.
// Input stream: one beat per vertex; tdata carries the vertex index and its
// adjacency row, tuser carries the start flag that marks every vertex
// uncolored before the beat is handled.
// Output stream: one beat per input beat with the vertex index and its stored
// color; tuser is high when a free color was found and stored.
// Config: i_cfg_we writes the vertex count (1..32, larger values cap at 32);
// write it only while no beat is in flight.
// Flow: after an input beat is taken, the core reads the stored color of
// each of the first n vertices, one per cycle through the single read port
// of the color store, keeping those of colored neighbors, then picks the
// lowest free color. The result passes through the pick and done states
// into the output register (an out-of-range vertex skips the reads), and
// the next input beat is taken only after that result is loaded.
// Reset clears all colored flags, sets the count to 32 and empties the output
// register; no clearing pass is needed. While the receiver stalls, the output
// register holds its beat, one more item is processed, and the core then
// waits with s_axis_tready low until the register frees.
module greedy_graph_coloring_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [5:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // [4:0] vertex, [36:5] neighbors, [39:37] zero
    input  logic        s_axis_tuser,  // [0] start_graph
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // [4:0] vertex_out, [9:5] color, [15:10] zero
    output logic        m_axis_tuser   // [0] assigned
);
    import ggc_pkg::*;

    t_cmd             w_cmd;
    t_sts             w_sts;
    logic [VTX_W-1:0] w_vertex_out;
    logic [VTX_W-1:0] w_color;

    ggc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    ggc_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_cfg_we     (i_cfg_we),
        .i_start      (s_axis_tuser),
        .i_vertex     (s_axis_tdata[4:0]),
        .i_neighbors  (s_axis_tdata[36:5]),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_vertex_out (w_vertex_out),
        .o_color      (w_color),
        .o_assigned   (m_axis_tuser)
    );

    // Pack the output beat
    assign m_axis_tdata = {6'd0, w_color, w_vertex_out};

endmodule

/* rtl/ggc_ctrl.sv */
module ggc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ggc_pkg::t_sts i_sts,
    output ggc_pkg::t_cmd o_cmd
);
    import ggc_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (!i_sts.in_range || i_sts.scan_last) n_state = ST_PICK;
            end
            ST_PICK: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            ST_SCAN: begin
                o_cmd.scan = i_sts.in_range;
            end
            ST_PICK: begin
                o_cmd.pick = 1'b1;
            end
            ST_DONE: begin
                o_cmd.load = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

/* rtl/ggc_dp.sv */
module ggc_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [ggc_pkg::CNT_W-1:0]     i_cfg_wdata,
    input  logic                          i_cfg_we,
    input  logic                          i_start,
    input  logic [ggc_pkg::VTX_W-1:0]     i_vertex,
    input  logic [ggc_pkg::ADJ_W-1:0]     i_neighbors,
    input  ggc_pkg::t_cmd                 i_cmd,
    output ggc_pkg::t_sts                 o_sts,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [ggc_pkg::VTX_W-1:0]     o_vertex_out,
    output logic [ggc_pkg::VTX_W-1:0]     o_color,
    output logic                          o_assigned
);
    import ggc_pkg::*;

    logic [CNT_W-1:0]       r_vcount;
    logic [CNT_W-1:0]       w_n;
    logic [VTX_W-1:0]       r_v;
    logic [ADJ_W-1:0]       r_adj;
    logic [VTX_W-1:0]       r_j;
    logic [STORE_DEPTH-1:0] r_flags;
    logic [VTX_W-1:0]       r_colors [STORE_DEPTH];
    logic [VTX_W-1:0]       w_rd_addr;
    logic [VTX_W-1:0]       r_rdata;
    logic                   r_acc_en;
    logic [ADJ_W-1:0]       r_blocked;
    logic [ADJ_W-1:0]       w_blocked;
    logic [ADJ_W-1:0]       w_free;
    logic [VTX_W-1:0]       w_pick;
    logic                   w_found;
    logic                   w_assign;
    logic                   r_assigned;
    logic [VTX_W-1:0]       r_pick;
    logic                   r_vflag;
    logic                   r_out_vld;
    logic [VTX_W-1:0]       r_out_vertex;
    logic [VTX_W-1:0]       r_out_color;
    logic                   r_out_assigned;

    // Hold the vertex count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= CNT_RESET;
        end else if (i_cfg_we) begin
            r_vcount <= i_cfg_wdata;
        end
    end

    assign w_n = (r_vcount > CNT_CAP) ? CNT_CAP : r_vcount;

    // Status toward the controller
    assign o_sts.in_range  = ({1'b0, r_v} < w_n);
    assign o_sts.scan_last = (({1'b0, r_j} + CNT_W'(1)) == w_n);
    assign o_sts.out_free  = !r_out_vld || i_out_ready;

    // Capture the input beat, step the neighbor index
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_v   <= i_vertex;
            r_adj <= i_neighbors;
            r_j   <= '0;
        end else if (i_cmd.scan) begin
            r_j   <= r_j + VTX_W'(1);
        end
    end

    // Colored flags: cleared by reset and by a start beat, set on assignment
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (i_cmd.accept && i_start) begin
            r_flags <= '0;
        end else if (w_assign) begin
            r_flags[r_v] <= 1'b1;
        end
    end

    // Color store: one write port, one registered read port; hold the read
    // data outside the scan and the pick so a stalled result keeps its color
    assign w_rd_addr = i_cmd.pick ? r_v : r_j;

    always_ff @(posedge i_clk) begin
        if (w_assign) begin
            r_colors[r_v] <= w_pick;
        end
        if (i_cmd.scan || i_cmd.pick) begin
            r_rdata <= r_colors[w_rd_addr];
        end
    end

    // Qualify the read in the cycle after its address, alongside the read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_en <= 1'b0;
        end else begin
            r_acc_en <= i_cmd.scan && r_adj[r_j] && r_flags[r_j];
        end
    end

    // Fold the latest neighbor color into the blocked set
    always_comb begin
        w_blocked = r_blocked;
        if (r_acc_en && ({1'b0, r_rdata} < w_n)) begin
            w_blocked = r_blocked | (ADJ_W'(1) << r_rdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_blocked <= '0;
        end else begin
            r_blocked <= w_blocked;
        end
    end

    // Pick the lowest free color below the count
    always_comb begin
        for (int i = 0; i < ADJ_W; i++) begin
            w_free[i] = !w_blocked[i] && (CNT_W'(i) < w_n);
        end
        w_pick = '0;
        for (int i = ADJ_W - 1; i >= 0; i--) begin
            if (w_free[i]) w_pick = VTX_W'(i);
        end
    end

    assign w_found  = |w_free;
    assign w_assign = i_cmd.pick && o_sts.in_range && w_found;

    always_ff @(posedge i_clk) begin
        if (i_cmd.pick) begin
            r_assigned <= w_assign;
            r_pick     <= w_pick;
            r_vflag    <= r_flags[r_v];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_vertex   <= r_v;
            r_out_assigned <= r_assigned;
            r_out_color    <= r_assigned ? r_pick : (r_vflag ? r_rdata : '0);
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_vertex_out = r_out_vertex;
    assign o_color      = r_out_color;
    assign o_assigned   = r_out_assigned;

    // A result never overwrites a beat still waiting
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> (!r_out_vld || i_out_ready))
        else $error("result loaded over a waiting beat");

    // An assigned vertex is in range and now marked colored
    a_assign_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.pick) && r_assigned |-> (({1'b0, r_v} < w_n) && r_flags[r_v]))
        else $error("assigned vertex not in range or not flagged");

    // The chosen color is not held by any colored neighbor
    a_pick_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.pick) && r_assigned |-> !r_blocked[r_pick])
        else $error("picked color is blocked");

endmodule
